// ===== src/mtcr_pkg.sv =====
// Shared types, constants and helper functions for the min/max trace column rasteriser.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package mtcr_pkg;

  localparam int unsigned NUM_COLUMNS_DEF = 84;

  localparam int unsigned COL_W   = 7;
  localparam int unsigned VAL_W   = 16;
  localparam int unsigned AXIS_W  = 15;
  localparam int unsigned RANGE_W = 4;
  localparam int unsigned CFG_W   = 15;
  localparam int unsigned WORD_W  = 32;

  // Rows run from -65534 to +32768; they are held in 18 signed bits.
  localparam int unsigned ROW_W = VAL_W + 2;

  // Division by the intercept uses a 2^24 scaled reciprocal and one correction step.
  localparam int unsigned RECIP_SHIFT = 24;
  localparam int unsigned RECIP_W     = RECIP_SHIFT + 1;
  localparam int unsigned DIV_W       = 10;

  localparam logic signed [VAL_W-1:0] EMPTY_MARK = 16'sd32000;
  localparam logic signed [VAL_W-1:0] HIGH_RESET = -16'sd32000;
  localparam logic [RANGE_W-1:0]      LAST_RANGE = 4'd9;

  typedef enum logic [0:0] {
    REQ_STORE  = 1'b0,
    REQ_RENDER = 1'b1
  } req_e;

  typedef enum logic [0:0] {
    CFG_AXIS_BOTTOM = 1'b0,
    CFG_RANGE_INDEX = 1'b1
  } cfg_reg_e;

  // Tag of one memory read: which render and which half of it.
  typedef struct packed {
    logic             vld;
    logic             prev_ph;
    logic             cursor;
    logic [COL_W-1:0] col;
  } rd_t;

  // Tag carried alongside the row units.
  typedef struct packed {
    logic             vld;
    logic             prev_ph;
    logic             empty;
    logic             cursor;
    logic [COL_W-1:0] col;
  } meta_t;

  function automatic logic [RECIP_W-1:0] recip_of(input logic [RANGE_W-1:0] sel);
    logic [RECIP_W-1:0] r;
    unique case (sel)
      4'd0:    r = 25'd16777216;
      4'd1:    r = 25'd8388608;
      4'd2:    r = 25'd3355443;
      4'd3:    r = 25'd1677721;
      4'd4:    r = 25'd838860;
      4'd5:    r = 25'd335544;
      4'd6:    r = 25'd167772;
      4'd7:    r = 25'd83886;
      4'd8:    r = 25'd41943;
      default: r = 25'd20971;
    endcase
    return r;
  endfunction

  function automatic logic [DIV_W-1:0] intercept_of(input logic [RANGE_W-1:0] sel);
    logic [DIV_W-1:0] d;
    unique case (sel)
      4'd0:    d = 10'd1;
      4'd1:    d = 10'd2;
      4'd2:    d = 10'd5;
      4'd3:    d = 10'd10;
      4'd4:    d = 10'd20;
      4'd5:    d = 10'd50;
      4'd6:    d = 10'd100;
      4'd7:    d = 10'd200;
      4'd8:    d = 10'd400;
      default: d = 10'd800;
    endcase
    return d;
  endfunction

  // Grid dots before bit reversal: dense on every tenth column, sparse on even ones.
  function automatic logic [WORD_W-1:0] grid_dots(input logic [COL_W-1:0] col);
    logic              tenth;
    logic [WORD_W-1:0] w;
    tenth = 1'b0;
    for (int k = 0; k < 13; k++) begin
      if (col == COL_W'(10 * k)) tenth = 1'b1;
    end
    w = tenth ? 32'hAAAA_AAAA : 32'h0;
    if (!col[0]) w = w | 32'h8020_0802;
    return w;
  endfunction

  function automatic logic [WORD_W-1:0] bit_reverse(input logic [WORD_W-1:0] x);
    logic [WORD_W-1:0] r;
    for (int i = 0; i < WORD_W; i++) begin
      r[i] = x[WORD_W-1-i];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/mtcr_row_unit.sv =====
// Pipelined row calculator: row = (value - axis_bottom) / intercept + 1, truncating.
// Three register stages; uses mtcr_pkg for widths and the range tables.
`timescale 1ns / 1ps
`default_nettype none

module mtcr_row_unit (
  input  logic                               clk_i,
  input  logic signed [mtcr_pkg::VAL_W-1:0]  value_i,
  input  logic [mtcr_pkg::AXIS_W-1:0]        axis_bottom_i,
  input  logic [mtcr_pkg::RANGE_W-1:0]       range_index_i,
  output logic signed [mtcr_pkg::ROW_W-1:0]  row_o
);

  localparam int unsigned VW     = mtcr_pkg::VAL_W;
  localparam int unsigned PROD_W = mtcr_pkg::VAL_W + mtcr_pkg::RECIP_W;
  localparam int unsigned QD_W   = mtcr_pkg::VAL_W + mtcr_pkg::DIV_W;
  localparam int unsigned SH     = mtcr_pkg::RECIP_SHIFT;

  logic [mtcr_pkg::RANGE_W-1:0] sel;
  logic [VW:0]                  diff;
  logic [VW:0]                  neg_diff;
  logic [VW-1:0]                mag_d;
  logic [VW-1:0]                mag_a_q, mag_b_q;
  logic                         neg_a_q, neg_b_q;
  logic [PROD_W-1:0]            prod;
  logic [VW-1:0]                q0_b_q;
  logic [QD_W-1:0]              qd;
  logic [VW:0]                  rem;
  logic [VW:0]                  quot;
  logic [mtcr_pkg::ROW_W-1:0]   row_d;
  logic [mtcr_pkg::ROW_W-1:0]   row_q;
  logic [mtcr_pkg::DIV_W-1:0]   divisor;

  // The user must hold configuration static while items are in flight; not enforced here.
  assign sel     = (range_index_i > mtcr_pkg::LAST_RANGE) ? mtcr_pkg::LAST_RANGE : range_index_i;
  assign divisor = mtcr_pkg::intercept_of(sel);

  // Stage A: signed difference, split into sign and magnitude.
  assign diff     = {value_i[VW-1], value_i} - {2'b00, axis_bottom_i};
  assign neg_diff = -diff;
  assign mag_d    = diff[VW] ? neg_diff[VW-1:0] : diff[VW-1:0];

  always_ff @(posedge clk_i) begin
    mag_a_q <= mag_d;
    neg_a_q <= diff[VW];
  end

  // Stage B: reciprocal estimate, low by at most one.
  assign prod = PROD_W'(mag_a_q) * PROD_W'(mtcr_pkg::recip_of(sel));

  always_ff @(posedge clk_i) begin
    q0_b_q  <= prod[SH+VW-1:SH];
    mag_b_q <= mag_a_q;
    neg_b_q <= neg_a_q;
  end

  // Stage C: remainder check, sign restored, then the one-row offset.
  assign qd   = QD_W'(q0_b_q) * QD_W'(divisor);
  assign rem  = {1'b0, mag_b_q} - qd[VW:0];
  assign quot = (rem >= (VW+1)'(divisor)) ? {1'b0, q0_b_q} + 1'b1 : {1'b0, q0_b_q};
  assign row_d = neg_b_q ? mtcr_pkg::ROW_W'(1) - {1'b0, quot}
                         : {1'b0, quot} + mtcr_pkg::ROW_W'(1);

  always_ff @(posedge clk_i) begin
    row_q <= row_d;
  end

  assign row_o = row_q;

endmodule

`default_nettype wire

// ===== src/minmax_trace_column_raster_top.sv =====
// Top level of the min/max trace column rasteriser: sample store, render pipeline, config.
// Depends on mtcr_pkg and mtcr_row_unit.
`timescale 1ns / 1ps
`default_nettype none

// Usage
// A request is taken on a rising edge with start high and busy low. req_type_i selects a
// store (column_i gets sample_min_i / sample_max_i) or a render of column_i. Requests whose
// column is at or beyond NUM_COLUMNS are taken and dropped without a result.
// A store does not raise busy; the next request may follow at once.
// A render reads the column first and then the previous column, both from the same
// single-port store, so busy is high for one cycle after each render and no request is taken
// while it is high. The result (out_column_o, column_bits_o) is shown for one cycle with
// done_o high, after the read, row unit and output registers; the receiver cannot hold it
// off, and new requests are taken while earlier renders are still in the pipeline.
// The config channel (cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i) is always ready and
// is to be written only while no render is in flight.
// Reset clears both config registers and marks every column empty at once through per-entry
// valid bits; no clearing pass is needed and the block accepts requests on the first cycle.

module minmax_trace_column_raster_top #(
  parameter int unsigned NUM_COLUMNS = mtcr_pkg::NUM_COLUMNS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [0:0]                          req_type_i,
  input  logic [mtcr_pkg::COL_W-1:0]          column_i,
  input  logic signed [mtcr_pkg::VAL_W-1:0]   sample_min_i,
  input  logic signed [mtcr_pkg::VAL_W-1:0]   sample_max_i,
  input  logic [mtcr_pkg::COL_W-1:0]          write_pointer_i,
  output logic                                done_o,
  output logic [mtcr_pkg::COL_W-1:0]          out_column_o,
  output logic [mtcr_pkg::WORD_W-1:0]         column_bits_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [0:0]                          cfg_index_i,
  input  logic [mtcr_pkg::CFG_W-1:0]          cfg_data_i
);

  localparam int unsigned IDX_W  = $clog2(NUM_COLUMNS);
  localparam int unsigned CW     = mtcr_pkg::COL_W;
  localparam int unsigned RW     = mtcr_pkg::ROW_W;
  localparam int unsigned DEPTH  = 3;

  // Config registers
  logic [mtcr_pkg::AXIS_W-1:0]  axis_bottom_q;
  logic [mtcr_pkg::RANGE_W-1:0] range_index_q;
  logic                         cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_bottom_q <= '0;
      range_index_q <= '0;
    end else if (cfg_we) begin
      if (cfg_index_i == mtcr_pkg::CFG_AXIS_BOTTOM) begin
        axis_bottom_q <= cfg_data_i[mtcr_pkg::AXIS_W-1:0];
      end else begin
        range_index_q <= cfg_data_i[mtcr_pkg::RANGE_W-1:0];
      end
    end
  end

  // Request decode
  logic             accept;
  logic             in_range;
  logic             store_en;
  logic             render_en;
  logic [IDX_W-1:0] col_addr;
  logic [IDX_W-1:0] prev_addr;
  logic [CW:0]      next_col;
  logic [CW:0]      wp_inc;
  logic             cursor;

  assign accept    = start && !busy;
  assign in_range  = {1'b0, column_i} < (CW+1)'(NUM_COLUMNS);
  assign store_en  = accept && in_range && (req_type_i == mtcr_pkg::REQ_STORE);
  assign render_en = accept && in_range && (req_type_i == mtcr_pkg::REQ_RENDER);
  assign col_addr  = column_i[IDX_W-1:0];
  assign prev_addr = (col_addr == '0) ? IDX_W'(NUM_COLUMNS - 1) : col_addr - 1'b1;
  assign wp_inc    = {1'b0, write_pointer_i} + 1'b1;
  assign next_col  = (wp_inc >= (CW+1)'(NUM_COLUMNS)) ? '0 : wp_inc;
  assign cursor    = ({1'b0, column_i} == next_col);

  // Second read of a render
  logic             busy_q;
  logic [IDX_W-1:0] prev_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= render_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (render_en) begin
      prev_addr_q <= prev_addr;
    end
  end

  assign busy = busy_q;

  // Sample store: one write or one read per cycle, registered read data.
  logic signed [mtcr_pkg::VAL_W-1:0] low_mem  [NUM_COLUMNS];
  logic signed [mtcr_pkg::VAL_W-1:0] high_mem [NUM_COLUMNS];
  logic [NUM_COLUMNS-1:0]            written_q;
  logic                              rd_en;
  logic [IDX_W-1:0]                  rd_addr;
  logic signed [mtcr_pkg::VAL_W-1:0] low_rd_q, high_rd_q;
  logic                              written_rd_q;
  mtcr_pkg::rd_t                     rd_q;

  assign rd_en   = render_en || busy_q;
  assign rd_addr = busy_q ? prev_addr_q : col_addr;

  always_ff @(posedge clk_i) begin
    if (store_en) begin
      low_mem[col_addr]  <= sample_min_i;
      high_mem[col_addr] <= sample_max_i;
    end
    if (rd_en) begin
      low_rd_q  <= low_mem[rd_addr];
      high_rd_q <= high_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q    <= '0;
      written_rd_q <= 1'b0;
      rd_q         <= '0;
    end else begin
      if (store_en) begin
        written_q[col_addr] <= 1'b1;
      end
      if (rd_en) begin
        written_rd_q <= written_q[rd_addr];
      end
      rd_q.vld     <= rd_en;
      rd_q.prev_ph <= busy_q;
      if (render_en) begin
        rd_q.cursor <= cursor;
        rd_q.col    <= column_i;
      end
    end
  end

  // An entry never written reads as its reset contents.
  logic signed [mtcr_pkg::VAL_W-1:0] low_val, high_val;
  logic                              empty;

  assign low_val  = written_rd_q ? low_rd_q  : mtcr_pkg::EMPTY_MARK;
  assign high_val = written_rd_q ? high_rd_q : mtcr_pkg::HIGH_RESET;
  assign empty    = (low_val == mtcr_pkg::EMPTY_MARK);

  // Row units, one per stored value
  logic signed [RW-1:0] row_lo, row_hi;

  mtcr_row_unit u_row_lo (
    .clk_i         (clk_i),
    .value_i       (low_val),
    .axis_bottom_i (axis_bottom_q),
    .range_index_i (range_index_q),
    .row_o         (row_lo)
  );

  mtcr_row_unit u_row_hi (
    .clk_i         (clk_i),
    .value_i       (high_val),
    .axis_bottom_i (axis_bottom_q),
    .range_index_i (range_index_q),
    .row_o         (row_hi)
  );

  // Tag pipeline matching the row unit latency
  mtcr_pkg::meta_t meta_q [DEPTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < DEPTH; s++) begin
        meta_q[s] <= '0;
      end
    end else begin
      meta_q[0].vld     <= rd_q.vld;
      meta_q[0].prev_ph <= rd_q.prev_ph;
      meta_q[0].empty   <= empty;
      meta_q[0].cursor  <= rd_q.cursor;
      meta_q[0].col     <= rd_q.col;
      for (int s = 1; s < DEPTH; s++) begin
        meta_q[s] <= meta_q[s-1];
      end
    end
  end

  // The current column's rows wait here for the previous column's rows.
  logic signed [RW-1:0] cmin_q, cmax_q;
  logic                 cur_empty_q;
  logic                 cur_cursor_q;
  logic [CW-1:0]        cur_col_q;
  logic                 cur_phase;
  logic                 prev_phase;

  assign cur_phase  = meta_q[DEPTH-1].vld && !meta_q[DEPTH-1].prev_ph;
  assign prev_phase = meta_q[DEPTH-1].vld &&  meta_q[DEPTH-1].prev_ph;

  always_ff @(posedge clk_i) begin
    if (cur_phase) begin
      cmin_q       <= row_lo;
      cmax_q       <= row_hi;
      cur_empty_q  <= meta_q[DEPTH-1].empty;
      cur_cursor_q <= meta_q[DEPTH-1].cursor;
      cur_col_q    <= meta_q[DEPTH-1].col;
    end
  end

  // Trace marks and fill between the two columns, clipped to rows 0..31.
  logic signed [RW-1:0]          pmin, pmax;
  logic signed [RW-1:0]          row_i;
  logic [mtcr_pkg::WORD_W-1:0]   trace;
  logic [mtcr_pkg::WORD_W-1:0]   word;
  logic [mtcr_pkg::WORD_W-1:0]   bits_d;

  assign pmin = meta_q[DEPTH-1].empty ? cmin_q : row_lo;
  assign pmax = meta_q[DEPTH-1].empty ? cmax_q : row_hi;

  always_comb begin
    row_i = '0;
    trace = '0;
    for (int i = 0; i < mtcr_pkg::WORD_W; i++) begin
      row_i    = RW'(i);
      trace[i] = (row_i > pmax   && row_i < cmax_q) ||
                 (row_i > cmin_q && row_i < pmin)   ||
                 (row_i > cmax_q && row_i < pmax)   ||
                 (row_i > pmin   && row_i < cmin_q) ||
                 (row_i == cmin_q) || (row_i == cmax_q);
    end
  end

  assign word   = mtcr_pkg::grid_dots(cur_col_q) | (cur_empty_q ? '0 : trace);
  assign bits_d = cur_cursor_q ? '1 : mtcr_pkg::bit_reverse(word);

  // Output register
  logic                        done_q;
  logic [CW-1:0]               out_column_q;
  logic [mtcr_pkg::WORD_W-1:0] column_bits_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= prev_phase;
    end
  end

  always_ff @(posedge clk_i) begin
    if (prev_phase) begin
      out_column_q  <= cur_col_q;
      column_bits_q <= bits_d;
    end
  end

  assign done_o        = done_q;
  assign out_column_o  = out_column_q;
  assign column_bits_o = column_bits_q;

endmodule

`default_nettype wire

// ===== src/mtcr_checker.sv =====
// Port-level checks for the min/max trace column rasteriser, bound to its top level.
// Depends on mtcr_pkg and minmax_trace_column_raster_top.
`timescale 1ns / 1ps
`default_nettype none

module mtcr_checker #(
  parameter int unsigned NUM_COLUMNS = mtcr_pkg::NUM_COLUMNS_DEF
) (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       start,
  input wire logic                       busy,
  input wire logic [0:0]                 req_type_i,
  input wire logic [mtcr_pkg::COL_W-1:0] column_i,
  input wire logic                       done_o,
  input wire logic [mtcr_pkg::COL_W-1:0] out_column_o
);

  logic render_req;

  assign render_req = start && !busy && (req_type_i == mtcr_pkg::REQ_RENDER) &&
                      ({1'b0, column_i} < (mtcr_pkg::COL_W+1)'(NUM_COLUMNS));

  // A render raises busy while it holds the store for its second read.
  assert property (@(posedge clk_i) disable iff (!rst_ni) render_req |=> busy)
    else $error("render request did not raise busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni) busy |=> !busy)
    else $error("busy held for more than one cycle");

  // Every result comes from an earlier render request.
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> $past(render_req, 6))
    else $error("result without a matching render request");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   done_o |-> (out_column_o == $past(column_i, 6)))
    else $error("result column does not match the request");

endmodule

bind minmax_trace_column_raster_top mtcr_checker #(.NUM_COLUMNS(NUM_COLUMNS)) u_mtcr_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start        (start),
  .busy         (busy),
  .req_type_i   (req_type_i),
  .column_i     (column_i),
  .done_o       (done_o),
  .out_column_o (out_column_o)
);

`default_nettype wire
